// File: rtl/lkv_pkg.sv
// shared types and constants for the lru key-value cache
`timescale 1ns / 1ps

package lkv_pkg;

  localparam int ENTRIES = 16;
  localparam int IDX_W   = $clog2(ENTRIES);
  localparam int OCC_W   = $clog2(ENTRIES + 1);
  localparam int KEY_W   = 32;
  localparam int VAL_W   = 32;
  localparam int CAP_W   = 5;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(ENTRIES);

  typedef enum logic {
    CMD_GET = 1'b0,
    CMD_PUT = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOOKUP,
    S_COMMIT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic lookup;
    logic commit;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_free;
  } dp_status_t;

endpackage

// File: rtl/lru_key_value_cache.sv
// top level of the lru key-value cache
`timescale 1ns / 1ps
// Fully associative key-value store of 16 entries with least-recently-used
// replacement. Input transactions on s_*: tuser is the operation (0 get,
// 1 put), tdata carries the key and the value to store. Each input yields
// exactly one output transaction on m_*: tuser flags hit and eviction,
// tdata carries the value read on a get hit and the key of an evicted entry
// (zero where not applicable).
// Every transaction passes through accept, a parallel key compare over
// all entries, then the commit of stores and recency ranks into the output
// register, in that sequence in the controller; a new transaction is taken only
// after the last one commits, and m_tvalid rises with the commit.
// The output register holds a finished result while the next transaction is
// accepted and looked up; commit waits while that register is still full
// and m_tready is low, which in turn holds s_tready low.
// The capacity register (cfg_we/cfg_wdata) limits entries in use before
// eviction; zero acts as one, values above 16 as 16. Write it only when idle.
// Reset empties the store and sets capacity to 16; no clearing pass.

module lru_key_value_cache (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [lkv_pkg::CAP_W-1:0]      cfg_wdata,   // capacity
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [lkv_pkg::KEY_W+lkv_pkg::VAL_W-1:0] s_tdata, // key, write_value
  input  logic                           s_tuser,     // cmd
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [lkv_pkg::VAL_W+lkv_pkg::KEY_W-1:0] m_tdata, // read_value, evicted_key
  output logic [1:0]                     m_tuser      // hit, evicted
);

  lkv_pkg::ctrl_cmd_t  cmd;
  lkv_pkg::dp_status_t status;

  lkv_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  lkv_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cmd       (cmd),
    .status    (status)
  );

endmodule

// File: rtl/lkv_ctrl.sv
// sequencing state machine: accept, lookup, commit
`timescale 1ns / 1ps

module lkv_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  lkv_pkg::dp_status_t status,
  output lkv_pkg::ctrl_cmd_t  cmd
);

  lkv_pkg::state_t state;
  lkv_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lkv_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    unique case (state)
      lkv_pkg::S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = lkv_pkg::S_LOOKUP;
        end
      end
      lkv_pkg::S_LOOKUP: begin
        cmd.lookup = 1'b1;
        state_next = lkv_pkg::S_COMMIT;
      end
      lkv_pkg::S_COMMIT: begin
        // wait for room in the output register
        if (status.out_free) begin
          cmd.commit = 1'b1;
          state_next = lkv_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = lkv_pkg::S_IDLE;
      end
    endcase
  end

endmodule

// File: rtl/lkv_datapath.sv
// entry stores, parallel key match, recency ranks and output register
`timescale 1ns / 1ps

module lkv_datapath (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_we,
  input  logic [lkv_pkg::CAP_W-1:0]             cfg_wdata,
  input  logic [lkv_pkg::KEY_W+lkv_pkg::VAL_W-1:0] s_tdata,
  input  logic                                  s_tuser,
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  output logic [lkv_pkg::VAL_W+lkv_pkg::KEY_W-1:0] m_tdata,
  output logic [1:0]                            m_tuser,
  input  lkv_pkg::ctrl_cmd_t                    cmd,
  output lkv_pkg::dp_status_t                   status
);

  localparam int N = lkv_pkg::ENTRIES;
  localparam int IW = lkv_pkg::IDX_W;
  localparam int OW = lkv_pkg::OCC_W;
  localparam int KW = lkv_pkg::KEY_W;
  localparam int VW = lkv_pkg::VAL_W;

  logic [KW-1:0]        key_store [N];
  logic [VW-1:0]        value_store [N];
  logic [N-1:0]         entry_valid;
  logic [IW-1:0]        rank [N];
  logic [IW-1:0]        rank_next [N];
  logic [OW-1:0]        occupancy;
  logic [lkv_pkg::CAP_W-1:0] capacity;

  lkv_pkg::op_t         req_op;
  logic [KW-1:0]        req_key;
  logic [VW-1:0]        req_wval;

  logic                 hit_q;
  logic                 evict_q;
  logic                 insert_q;
  logic [IW-1:0]        sel_idx;

  logic                 hit_any;
  logic [IW-1:0]        hit_idx;
  logic [IW-1:0]        victim_idx;
  logic [IW-1:0]        free_idx;
  logic [OW-1:0]        eff_cap;
  logic [OW-1:0]        occ_m1;
  logic                 full;
  logic                 do_promote;
  logic [IW-1:0]        lim;

  always_comb begin
    if (capacity == '0) begin
      eff_cap = OW'(1);
    end else if (OW'(capacity) > OW'(N)) begin
      eff_cap = OW'(N);
    end else begin
      eff_cap = OW'(capacity);
    end
  end

  assign full   = occupancy >= eff_cap;
  assign occ_m1 = occupancy - OW'(1);

  // lowest index wins in each search
  always_comb begin
    hit_any    = 1'b0;
    hit_idx    = '0;
    victim_idx = '0;
    free_idx   = '0;
    for (int i = N - 1; i >= 0; i--) begin
      if (entry_valid[i] && key_store[i] == req_key) begin
        hit_any = 1'b1;
        hit_idx = IW'(i);
      end
      // valid ranks form 0..occupancy-1, so the oldest has rank occupancy-1
      if (entry_valid[i] && rank[i] == occ_m1[IW-1:0]) begin
        victim_idx = IW'(i);
      end
      if (!entry_valid[i]) begin
        free_idx = IW'(i);
      end
    end
  end

  assign do_promote = hit_q || evict_q || insert_q;
  assign lim        = rank[sel_idx];

  always_comb begin
    for (int i = 0; i < N; i++) begin
      rank_next[i] = rank[i];
      if (do_promote) begin
        if (IW'(i) == sel_idx) begin
          rank_next[i] = '0;
        end else if (entry_valid[i] && (insert_q || rank[i] < lim)) begin
          rank_next[i] = rank[i] + IW'(1);
        end
      end
    end
  end

  assign status.out_free = !m_tvalid || m_tready;

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity    <= lkv_pkg::CAP_RESET;
      entry_valid <= '0;
      occupancy   <= '0;
      m_tvalid    <= 1'b0;
      hit_q       <= 1'b0;
      evict_q     <= 1'b0;
      insert_q    <= 1'b0;
      for (int i = 0; i < N; i++) begin
        rank[i] <= '0;
      end
    end else begin
      if (cfg_we) begin
        capacity <= cfg_wdata;
      end
      if (cmd.lookup) begin
        hit_q    <= hit_any;
        evict_q  <= !hit_any && req_op == lkv_pkg::CMD_PUT && full;
        insert_q <= !hit_any && req_op == lkv_pkg::CMD_PUT && !full;
      end
      if (cmd.commit) begin
        for (int i = 0; i < N; i++) begin
          rank[i] <= rank_next[i];
        end
        if (insert_q) begin
          entry_valid[sel_idx] <= 1'b1;
          occupancy            <= occupancy + OW'(1);
        end
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_op   <= lkv_pkg::op_t'(s_tuser);
      req_key  <= s_tdata[KW-1:0];
      req_wval <= s_tdata[KW+VW-1:KW];
    end
    if (cmd.lookup) begin
      if (hit_any) begin
        sel_idx <= hit_idx;
      end else if (full) begin
        sel_idx <= victim_idx;
      end else begin
        sel_idx <= free_idx;
      end
    end
    if (cmd.commit) begin
      m_tuser <= {evict_q, hit_q};
      m_tdata[VW-1:0] <= (hit_q && req_op == lkv_pkg::CMD_GET) ?
                         value_store[sel_idx] : '0;
      m_tdata[VW+KW-1:VW] <= evict_q ? key_store[sel_idx] : '0;
      if (req_op == lkv_pkg::CMD_PUT) begin
        value_store[sel_idx] <= req_wval;
      end
      if (evict_q || insert_q) begin
        key_store[sel_idx] <= req_key;
      end
    end
  end

endmodule

// File: dv/lru_result_checker.sv
// result checker for the lru key-value cache: predicts each access and compares outputs
`timescale 1ns / 1ps

module lru_result_checker
  import lkv_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CAP_W-1:0]       cfg_wdata,
  input  logic                   s_tvalid,
  input  logic                   s_tready,
  input  logic [KEY_W+VAL_W-1:0] s_tdata,   // key, write_value
  input  logic                   s_tuser,   // cmd
  input  logic                   m_tvalid,
  input  logic                   m_tready,
  input  logic [VAL_W+KEY_W-1:0] m_tdata,   // read_value, evicted_key
  input  logic [1:0]             m_tuser,   // hit, evicted
  output int                     mismatches,
  output int                     outstanding,
  output int                     checked,
  output int                     hits,
  output int                     evictions
);

  typedef struct packed {
    logic             hit;
    logic [VAL_W-1:0] read_value;
    logic             evicted;
    logic [KEY_W-1:0] evicted_key;
  } access_result_t;

  logic [KEY_W-1:0] key_mem   [ENTRIES];
  logic [VAL_W-1:0] value_mem [ENTRIES];
  bit               slot_valid[ENTRIES];
  int               age_rank  [ENTRIES];
  int               filled;
  logic [CAP_W-1:0] capacity;

  access_result_t   expected_results[$];

  // slot becomes most recent; valid entries younger than limit get one older
  function automatic void make_recent(int slot, int limit);
    for (int i = 0; i < ENTRIES; i++) begin
      if (i != slot && slot_valid[i] && age_rank[i] < limit) age_rank[i]++;
    end
    age_rank[slot] = 0;
  endfunction

  function automatic void predict_access(input op_t op, input logic [KEY_W-1:0] k,
                                         input logic [VAL_W-1:0] v,
                                         output access_result_t res);
    int found;
    int victim;
    int oldest;
    int eff_cap;
    res = '0;
    found = -1;
    victim = -1;
    oldest = 0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (slot_valid[i] && key_mem[i] == k) begin
        found = i;
        break;
      end
    end
    if (found >= 0) begin
      res.hit = 1'b1;
      if (op == CMD_GET) res.read_value = value_mem[found];
      else value_mem[found] = v;
      make_recent(found, age_rank[found]);
      return;
    end
    if (op == CMD_GET) return;
    // zero capacity acts as one, anything above the entry count saturates
    eff_cap = (capacity == 0) ? 1 : ((capacity > ENTRIES) ? ENTRIES : int'(capacity));
    if (filled >= eff_cap) begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (slot_valid[i] && (victim < 0 || age_rank[i] > oldest)) begin
          victim = i;
          oldest = age_rank[i];
        end
      end
      if (victim >= 0) begin
        res.evicted = 1'b1;
        res.evicted_key = key_mem[victim];
        key_mem[victim] = k;
        value_mem[victim] = v;
        make_recent(victim, oldest);
        return;
      end
    end
    for (int i = 0; i < ENTRIES; i++) begin
      if (!slot_valid[i]) begin
        key_mem[i] = k;
        value_mem[i] = v;
        slot_valid[i] = 1'b1;
        make_recent(i, ENTRIES + 1);
        filled++;
        break;
      end
    end
  endfunction

  always @(posedge clk) begin : watch
    access_result_t exp_r;
    access_result_t got_r;
    if (rst) begin
      for (int i = 0; i < ENTRIES; i++) begin
        slot_valid[i] = 1'b0;
        age_rank[i] = 0;
        key_mem[i] = '0;
        value_mem[i] = '0;
      end
      filled = 0;
      capacity = CAP_RESET;
      expected_results.delete();
      mismatches = 0;
      outstanding = 0;
      checked = 0;
      hits = 0;
      evictions = 0;
    end else begin
      if (cfg_we) capacity = cfg_wdata;
      if (m_tvalid && m_tready) begin
        got_r.hit = m_tuser[0];
        got_r.evicted = m_tuser[1];
        got_r.read_value = m_tdata[VAL_W-1:0];
        got_r.evicted_key = m_tdata[VAL_W +: KEY_W];
        if (expected_results.size() == 0) begin
          $display("%0t: result transaction with nothing expected: hit=%b read_value=%h evicted=%b evicted_key=%h",
                   $time, got_r.hit, got_r.read_value, got_r.evicted, got_r.evicted_key);
          mismatches++;
        end else begin
          exp_r = expected_results.pop_front();
          checked++;
          if (got_r !== exp_r) begin
            $display("%0t: mismatch expected hit=%b read_value=%h evicted=%b evicted_key=%h",
                     $time, exp_r.hit, exp_r.read_value, exp_r.evicted, exp_r.evicted_key);
            $display("%0t:          actual   hit=%b read_value=%h evicted=%b evicted_key=%h",
                     $time, got_r.hit, got_r.read_value, got_r.evicted, got_r.evicted_key);
            mismatches++;
          end
        end
      end
      if (s_tvalid && s_tready) begin
        predict_access(op_t'(s_tuser), s_tdata[KEY_W-1:0], s_tdata[KEY_W +: VAL_W], exp_r);
        expected_results.push_back(exp_r);
        if (exp_r.hit) hits++;
        if (exp_r.evicted) evictions++;
      end
      outstanding = expected_results.size();
    end
  end

endmodule

// File: dv/testbench.sv
// top of the lru key-value cache testbench: clock, reset, stimulus and verdict
`timescale 1ns / 1ps

module testbench;
  import lkv_pkg::*;

  logic                   clk = 1'b0;
  logic                   rst;
  logic                   cfg_we;
  logic [CAP_W-1:0]       cfg_wdata;
  logic                   s_tvalid;
  logic                   s_tready;
  logic [KEY_W+VAL_W-1:0] s_tdata;   // key, write_value
  logic                   s_tuser;   // cmd
  logic                   m_tvalid;
  logic                   m_tready;
  logic [VAL_W+KEY_W-1:0] m_tdata;   // read_value, evicted_key
  logic [1:0]             m_tuser;   // hit, evicted

  int mismatches;
  int outstanding;
  int checked;
  int hits;
  int evictions;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int txn_count = 0;
  int cap_writes = 0;

  always #6 clk = ~clk;

  lru_key_value_cache dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  lru_result_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .mismatches (mismatches),
    .outstanding(outstanding),
    .checked    (checked),
    .hits       (hits),
    .evictions  (evictions)
  );

  always @(negedge clk) begin
    if (recv_stall_pct == 0) m_tready <= 1'b1;
    else m_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // entered and left at a falling edge; valid stays up into the next call
  task automatic send_access(input op_t op, input logic [KEY_W-1:0] k,
                             input logic [VAL_W-1:0] v);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= op;
    s_tdata <= {v, k};
    do @(posedge clk); while (!s_tready);
    txn_count++;
    @(negedge clk);
  endtask

  // write capacity only once the cache has drained
  task automatic set_capacity(input logic [CAP_W-1:0] cap);
    s_tvalid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= cap;
    @(negedge clk);
    cfg_we <= 1'b0;
    cap_writes++;
  endtask

  task automatic set_idling(input int mode);
    case (mode % 4)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 62; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 62; end
      default: begin send_idle_pct = 16; recv_stall_pct = 16; end
    endcase
  endtask

  task automatic random_phase(input logic [CAP_W-1:0] cap, input int n_items);
    logic [KEY_W-1:0] key_pool[32];
    logic [KEY_W-1:0] k;
    logic [VAL_W-1:0] v;
    int eff_cap;
    int pool_n;
    int r;
    eff_cap = (cap == 0) ? 1 : ((cap > ENTRIES) ? ENTRIES : int'(cap));
    // pool a bit larger than the capacity so hits, misses and evictions all occur
    pool_n = $urandom_range(eff_cap + 1, (2 * eff_cap + 4 > 32) ? 32 : 2 * eff_cap + 4);
    for (int i = 0; i < 32; i++) begin
      r = $urandom_range(15);
      key_pool[i] = (r == 0) ? '0 : ((r == 1) ? '1 : KEY_W'($urandom));
    end
    for (int n = 0; n < n_items; n++) begin
      r = $urandom_range(99);
      k = (r < 8) ? KEY_W'($urandom) : key_pool[$urandom_range(pool_n - 1)];
      r = $urandom_range(15);
      v = (r == 0) ? '0 : ((r == 1) ? '1 : VAL_W'($urandom));
      send_access($urandom_range(1) ? CMD_PUT : CMD_GET, k, v);
    end
  endtask

  initial begin
    logic [CAP_W-1:0] cap_plan[11];
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = 1'b0;
    m_tready = 1'b0;
    cap_plan = '{5'd16, 5'd1, 5'd2, 5'd31, 5'd3, 5'd0, 5'd8, 5'd12, 5'd16, 5'd5, 5'd20};
    cap_plan[7] = CAP_W'($urandom_range(4, 15));
    cap_plan[10] = CAP_W'($urandom_range(31));
    repeat (11) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: empty store, extreme keys and values, update in place
    send_access(CMD_GET, 32'h0000_0000, 32'h0000_0000);
    send_access(CMD_PUT, 32'h0000_0000, 32'hFFFF_FFFF);
    send_access(CMD_GET, 32'h0000_0000, 32'h0000_0000);
    send_access(CMD_PUT, 32'hFFFF_FFFF, 32'h0000_0000);
    send_access(CMD_GET, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_access(CMD_PUT, 32'h0000_0000, 32'h1234_5678);
    send_access(CMD_GET, 32'h0000_0000, 32'h0000_0000);
    send_access(CMD_GET, 32'h5555_5555, 32'h0000_0000);
    // zero capacity acts as one, and drops below the two entries held
    set_capacity('0);
    send_access(CMD_PUT, 32'hAAAA_AAAA, 32'h5555_5555);
    send_access(CMD_PUT, 32'h5555_5555, 32'hAAAA_AAAA);
    send_access(CMD_GET, 32'hAAAA_AAAA, 32'h0000_0000);
    send_access(CMD_GET, 32'h5555_5555, 32'h0000_0000);

    for (int p = 0; p < 11; p++) begin
      set_capacity(cap_plan[p]);
      set_idling(p);
      random_phase(cap_plan[p], 118);
    end

    s_tvalid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    $display("%0d accesses sent across %0d capacity writes (0, 1, 16, 31 among them)",
             txn_count, cap_writes);
    $display("%0d results checked: %0d hits, %0d evictions", checked, hits, evictions);
    if (mismatches == 0 && outstanding == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("testbench failed");
    $finish;
  end

endmodule
